// File: hdl/grmm_pkg.sv
// ----------------------------------------------------------------------------
// grmm_pkg: shared types and constants for the group rank membership map
// Command and response words, operation codes, sequencer states, cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package grmm_pkg;

	localparam int MAX_UNITS = 64;
	localparam int IDX_W     = $clog2(MAX_UNITS);
	localparam int COUNT_W   = $clog2(MAX_UNITS + 1);
	localparam int UID_W     = 6;
	// width wide enough to compare a unit id against a cell index
	localparam int CMP_W     = (IDX_W > UID_W) ? IDX_W : UID_W;
	// width wide enough to compare a requested rank against a running count
	localparam int SEEN_W    = (COUNT_W > UID_W) ? COUNT_W : UID_W;

	typedef enum logic [1:0] {
		MODE_ADD        = 2'd0,
		MODE_REMOVE     = 2'd1,
		MODE_QUERY_ID   = 2'd2,
		MODE_QUERY_RANK = 2'd3
	} grmm_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} grmm_state_t;

	typedef struct packed {
		grmm_mode_t  mode;
		logic [5:0]  unit_id;
		logic [5:0]  rank_in;
	} grmm_req_t;

	typedef struct packed {
		logic        is_member;
		logic [5:0]  local_rank;
		logic [5:0]  global_id;
		logic        rank_found;
		logic [6:0]  member_count;
	} grmm_rsp_t;

	typedef struct packed {
		logic shift;
		logic wr;
		logic wr_val;
	} grmm_cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/grmm_cell.sv
// ----------------------------------------------------------------------------
// grmm_cell: one membership slot of the rotating bitmap ring
// Holds one bit; takes its neighbor's bit on a shift, else loads on a write.
// ----------------------------------------------------------------------------
`default_nettype none

module grmm_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire grmm_pkg::grmm_cell_ctl_t ctl,
	input  wire logic                    sel,
	input  wire logic                    nbr_bit,
	output logic                         bit_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.shift) begin
			bit_q <= nbr_bit;
		end else if (ctl.wr && sel) begin
			bit_q <= ctl.wr_val;
		end
	end

endmodule

`default_nettype wire

// File: hdl/grmm_scan.sv
// ----------------------------------------------------------------------------
// grmm_scan: scan sequencer at the head of the ring
// Walks the ring one slot a cycle, counting ranks and selecting by rank.
// ----------------------------------------------------------------------------
`default_nettype none

module grmm_scan (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         launch,
	input  wire grmm_pkg::grmm_req_t          req,
	input  wire logic                         head_bit,
	input  wire logic [grmm_pkg::COUNT_W-1:0] total,
	output logic                              shift,
	output logic                              busy,
	output logic                              done,
	output grmm_pkg::grmm_rsp_t               rsp
);

	grmm_pkg::grmm_state_t state_q, state_d;

	logic [grmm_pkg::IDX_W-1:0]   step_q;
	logic                         last_step;
	grmm_pkg::grmm_mode_t         mode_q;
	logic [5:0]                   uid_q;
	logic [5:0]                   rank_q;
	logic [grmm_pkg::COUNT_W-1:0] cnt_q;
	logic [grmm_pkg::SEEN_W-1:0]  seen_q;
	logic [grmm_pkg::IDX_W-1:0]   gid_q;
	logic                         found_q;
	logic                         member_q;
	logic                         below;
	logic                         at_uid;

	assign last_step = (step_q == grmm_pkg::IDX_W'(grmm_pkg::MAX_UNITS - 1));
	assign below  = (grmm_pkg::CMP_W'(step_q) < grmm_pkg::CMP_W'(uid_q));
	assign at_uid = (grmm_pkg::CMP_W'(step_q) == grmm_pkg::CMP_W'(uid_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			grmm_pkg::ST_IDLE: begin
				if (launch) state_d = grmm_pkg::ST_SCAN;
			end
			grmm_pkg::ST_SCAN: begin
				if (last_step) state_d = grmm_pkg::ST_DONE;
			end
			grmm_pkg::ST_DONE: begin
				state_d = launch ? grmm_pkg::ST_SCAN : grmm_pkg::ST_IDLE;
			end
			default: state_d = grmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		shift = 1'b0;
		busy  = 1'b0;
		done  = 1'b0;
		case (state_q)
			grmm_pkg::ST_IDLE: begin
			end
			grmm_pkg::ST_SCAN: begin
				shift = 1'b1;
				busy  = 1'b1;
			end
			grmm_pkg::ST_DONE: begin
				done = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grmm_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (shift) step_q <= last_step ? '0 : step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			mode_q   <= req.mode;
			uid_q    <= req.unit_id;
			rank_q   <= req.rank_in;
			cnt_q    <= '0;
			seen_q   <= '0;
			gid_q    <= '0;
			found_q  <= 1'b0;
			member_q <= 1'b0;
		end else if (shift) begin
			if (below && head_bit) cnt_q <= cnt_q + 1'b1;
			if (at_uid) member_q <= head_bit;
			// first member whose running count equals the requested rank wins
			if (mode_q == grmm_pkg::MODE_QUERY_RANK && head_bit && !found_q) begin
				if (seen_q == grmm_pkg::SEEN_W'(rank_q)) begin
					found_q <= 1'b1;
					gid_q   <= step_q;
				end
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	always_comb begin
		rsp.is_member    = member_q;
		rsp.local_rank   = 6'(cnt_q);
		rsp.global_id    = 6'(gid_q);
		rsp.rank_found   = found_q;
		rsp.member_count = 7'(total);
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_found_rank_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.rank_found) |-> (mode_q == grmm_pkg::MODE_QUERY_RANK))
		else $error("rank found outside a rank query");

	a_no_gid_unfound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.rank_found) |-> (rsp.global_id == 6'd0))
		else $error("global id nonzero without a rank hit");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != grmm_pkg::ST_SCAN) |-> (step_q == '0))
		else $error("step counter not parked outside a scan");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && last_step) |=> done)
		else $error("scan ended without a result strobe");

endmodule

`default_nettype wire

// File: hdl/group_rank_membership_map.sv
// ----------------------------------------------------------------------------
// group_rank_membership_map: membership bitmap with rank and select queries
// A ring of one-bit cells rotates once per word past a scan sequencer.
// ----------------------------------------------------------------------------
// Flow: a taken word starts one full turn of the 64-cell ring, one slot past
//   the head per cycle, and the result strobe follows the turn. A new word
//   is taken only once the last one's turn is over; start is taken again
//   during the strobe cycle.
// Reset: arst_n clears all membership bits, the count and the sequencer.
// The receiver cannot stall: each result is on rsp for the one cycle of done.
`default_nettype none

module group_rank_membership_map (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire grmm_pkg::grmm_req_t req,
	output logic                     busy,
	output logic                     done,
	output grmm_pkg::grmm_rsp_t      rsp
);

	logic [grmm_pkg::MAX_UNITS-1:0] bits;
	logic [grmm_pkg::MAX_UNITS-1:0] sel;
	logic [grmm_pkg::COUNT_W-1:0]   total_q;
	grmm_pkg::grmm_cell_ctl_t       ctl;
	logic                           launch;
	logic                           shift;
	logic                           cur_bit;
	logic                           do_add;
	logic                           do_rem;

	assign launch  = start && !busy;
	assign cur_bit = |(bits & sel);
	assign do_add  = launch && (req.mode == grmm_pkg::MODE_ADD) && !cur_bit && (|sel);
	assign do_rem  = launch && (req.mode == grmm_pkg::MODE_REMOVE) && cur_bit;

	always_comb begin
		ctl.shift  = shift;
		ctl.wr     = do_add || do_rem;
		ctl.wr_val = do_add;
	end

	for (genvar k = 0; k < grmm_pkg::MAX_UNITS; k++) begin : g_cell
		assign sel[k] = (grmm_pkg::CMP_W'(req.unit_id) == grmm_pkg::CMP_W'(k));

		grmm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel     (sel[k]),
			.nbr_bit (bits[(k + 1) % grmm_pkg::MAX_UNITS]),
			.bit_q   (bits[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (do_add) begin
			total_q <= total_q + 1'b1;
		end else if (do_rem) begin
			total_q <= total_q - 1'b1;
		end
	end

	grmm_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.req      (req),
		.head_bit (bits[0]),
		.total    (total_q),
		.shift    (shift),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for group_rank_membership_map
// Commands queued up front are fed to the block by a clocked driver under
// varying sender idle mixes. A shadow bitmap predicts each response at the
// accepting edge. The monitor compares every strobed response against the
// oldest prediction. Coverage: directed corner commands, then grow, shrink,
// even and full-fill mixes of random commands.
// ----------------------------------------------------------------------------

module tb;

	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 130;
	localparam int RANDOM_BLOCKS = 16;
	localparam int BLOCK_ITEMS   = 100;
	localparam int REPORT_MAX    = 10;

	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN
	} mix_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	grmm_pkg::grmm_req_t req    = '0;
	logic                busy;
	logic                done;
	grmm_pkg::grmm_rsp_t rsp;

	grmm_pkg::grmm_req_t cmd_q[$];
	grmm_pkg::grmm_rsp_t rsp_expected_q[$];
	grmm_pkg::grmm_rsp_t rsp_want;

	// shadow of the block's map
	logic [grmm_pkg::MAX_UNITS-1:0] member_bits  = '0;
	logic [grmm_pkg::COUNT_W-1:0]   member_total = '0;

	int total_cmds    = 0;
	int accepted_cmds = 0;
	int checked_rsps  = 0;
	int mismatches    = 0;
	int stall_cycles  = 0;
	int peak_total    = 0;

	group_rank_membership_map DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one command to the shadow map and return the response it causes.
	function automatic grmm_pkg::grmm_rsp_t map_step(input grmm_pkg::grmm_req_t cmd);
		grmm_pkg::grmm_rsp_t            r;
		logic [grmm_pkg::MAX_UNITS-1:0] below_mask;
		int                             seen;
		r = '0;
		if (cmd.mode == grmm_pkg::MODE_ADD && !member_bits[cmd.unit_id]) begin
			member_bits[cmd.unit_id] = 1'b1;
			member_total = member_total + 1'b1;
		end else if (cmd.mode == grmm_pkg::MODE_REMOVE && member_bits[cmd.unit_id]) begin
			member_bits[cmd.unit_id] = 1'b0;
			member_total = member_total - 1'b1;
		end
		r.is_member = member_bits[cmd.unit_id];
		below_mask = '1;
		below_mask = ~(below_mask << cmd.unit_id);
		r.local_rank = 6'($countones(member_bits & below_mask));
		if (cmd.mode == grmm_pkg::MODE_QUERY_RANK && cmd.rank_in < member_total) begin
			seen = 0;
			for (int i = 0; i < grmm_pkg::MAX_UNITS; i++) begin
				if (member_bits[i]) begin
					if (seen == cmd.rank_in && !r.rank_found) begin
						r.global_id  = 6'(i);
						r.rank_found = 1'b1;
					end
					seen++;
				end
			end
		end
		r.member_count = member_total;
		if (member_total > peak_total)
			peak_total = member_total;
		return r;
	endfunction

	function automatic void push_cmd(input grmm_pkg::grmm_mode_t m, input int uid,
			input int rank);
		grmm_pkg::grmm_req_t c;
		c.mode    = m;
		c.unit_id = 6'(uid);
		c.rank_in = 6'(rank);
		cmd_q.push_back(c);
	endfunction

	function automatic grmm_pkg::grmm_mode_t pick_mode(input mix_t mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				if (r < 50) return grmm_pkg::MODE_ADD;
				if (r < 60) return grmm_pkg::MODE_REMOVE;
				if (r < 80) return grmm_pkg::MODE_QUERY_ID;
				return grmm_pkg::MODE_QUERY_RANK;
			end
			MIX_SHRINK: begin
				if (r < 10) return grmm_pkg::MODE_ADD;
				if (r < 50) return grmm_pkg::MODE_REMOVE;
				if (r < 75) return grmm_pkg::MODE_QUERY_ID;
				return grmm_pkg::MODE_QUERY_RANK;
			end
			default: return grmm_pkg::grmm_mode_t'(r % 4);
		endcase
	endfunction

	// Driver: present the head of the queue, hold it until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				rsp_expected_q.push_back(map_step(req));
				void'(cmd_q.pop_front());
				accepted_cmds++;
			end
			if (!(start && busy)) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >=
						((accepted_cmds < total_cmds / 3) ? 32 :
						(accepted_cmds < 2 * total_cmds / 3) ? 74 : 0)) begin
					start <= 1'b1;
					req   <= cmd_q[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each strobed word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (done) begin
				checked_rsps++;
				if (rsp_expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"mismatch: response with none pending: ",
							"mem=%0d rank=%0d gid=%0d found=%0d cnt=%0d"},
							rsp.is_member, rsp.local_rank, rsp.global_id,
							rsp.rank_found, rsp.member_count);
				end else begin
					rsp_want = rsp_expected_q.pop_front();
					if (rsp.is_member !== rsp_want.is_member ||
							rsp.local_rank !== rsp_want.local_rank ||
							rsp.global_id !== rsp_want.global_id ||
							rsp.rank_found !== rsp_want.rank_found ||
							rsp.member_count !== rsp_want.member_count) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display({"mismatch at response %0d: expected ",
								"mem=%0d rank=%0d gid=%0d found=%0d cnt=%0d"},
								checked_rsps, rsp_want.is_member,
								rsp_want.local_rank, rsp_want.global_id,
								rsp_want.rank_found, rsp_want.member_count);
							$display("    actual mem=%0d rank=%0d gid=%0d found=%0d cnt=%0d",
								rsp.is_member, rsp.local_rank, rsp.global_id,
								rsp.rank_found, rsp.member_count);
						end
					end
				end
			end
		end
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		int   ids[grmm_pkg::MAX_UNITS];
		int   j;
		int   tmp;
		mix_t mix;

		// empty map corners
		push_cmd(grmm_pkg::MODE_QUERY_ID, 0, 0);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 63, 0);
		push_cmd(grmm_pkg::MODE_REMOVE, 5, 63);
		// lowest and highest ids, duplicate add
		push_cmd(grmm_pkg::MODE_ADD, 0, 0);
		push_cmd(grmm_pkg::MODE_ADD, 63, 63);
		push_cmd(grmm_pkg::MODE_ADD, 0, 21);
		push_cmd(grmm_pkg::MODE_QUERY_ID, 63, 42);
		push_cmd(grmm_pkg::MODE_QUERY_ID, 0, 0);
		push_cmd(grmm_pkg::MODE_QUERY_ID, 62, 0);
		// rank select, found and past the count
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 0, 0);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 63, 1);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 0, 2);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 0, 63);
		push_cmd(grmm_pkg::MODE_ADD, 42, 42);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 21, 1);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 42, 2);
		// remove twice, second one is a no-op
		push_cmd(grmm_pkg::MODE_REMOVE, 63, 0);
		push_cmd(grmm_pkg::MODE_REMOVE, 63, 63);
		push_cmd(grmm_pkg::MODE_QUERY_ID, 63, 0);
		push_cmd(grmm_pkg::MODE_REMOVE, 0, 0);
		push_cmd(grmm_pkg::MODE_REMOVE, 42, 0);
		push_cmd(grmm_pkg::MODE_QUERY_RANK, 63, 0);

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			if (b == 5 || b == 12) begin
				// fill the whole map in shuffled order, then probe the top
				for (int i = 0; i < grmm_pkg::MAX_UNITS; i++)
					ids[i] = i;
				for (int i = grmm_pkg::MAX_UNITS - 1; i > 0; i--) begin
					j = $urandom_range(i);
					tmp = ids[i];
					ids[i] = ids[j];
					ids[j] = tmp;
				end
				for (int i = 0; i < grmm_pkg::MAX_UNITS; i++)
					push_cmd(grmm_pkg::MODE_ADD, ids[i], $urandom_range(63));
				push_cmd(grmm_pkg::MODE_QUERY_RANK, $urandom_range(63), 63);
				push_cmd(grmm_pkg::MODE_QUERY_RANK, $urandom_range(63), 0);
				push_cmd(grmm_pkg::MODE_QUERY_ID, 63, $urandom_range(63));
				for (int i = 0; i < 17; i++)
					push_cmd(i[0] ? grmm_pkg::MODE_QUERY_RANK : grmm_pkg::MODE_QUERY_ID,
						$urandom_range(63), $urandom_range(63));
			end else begin
				case (b % 4)
					0, 1:    mix = MIX_GROW;
					2:       mix = MIX_EVEN;
					default: mix = MIX_SHRINK;
				endcase
				for (int i = 0; i < BLOCK_ITEMS; i++)
					push_cmd(pick_mode(mix), $urandom_range(63), $urandom_range(63));
			end
		end
		total_cmds = cmd_q.size();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_q.size() != 0 || rsp_expected_q.size() != 0)
			@(posedge clk);
		// drain: catch any stray strobe after the last expected word
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d commands taken, %0d responses checked, %0d mismatches",
			accepted_cmds, checked_rsps, mismatches);
		$display("summary: member count peaked at %0d; sender idled 32%%, 74%%, then not at all",
			peak_total);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
hdl/grmm_pkg.sv
hdl/grmm_cell.sv
hdl/grmm_scan.sv
hdl/group_rank_membership_map.sv
tb/sv/tb.sv
